[hdl/ltp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltp_pkg
// Shared types and constants for the lottery task picker.
// ----------------------------------------------------------------------------
package ltp_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int CEILING_DEF = 8;
	localparam int TICKETS_DEF = 1600;

	localparam int ID_W    = 10;
	localparam int PRIO_W  = 3;
	localparam int SLEEP_W = 16;
	localparam int SLOT_W  = 4;
	localparam int DRAW_W  = 11;

	// func codes of an input beat
	localparam logic FUNC_SCHED = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// one task slot as held in a cell
	typedef struct packed {
		logic               occ;
		logic               rdy;
		logic [PRIO_W-1:0]  prio;
		logic [SLEEP_W-1:0] sleep;
		logic [ID_W-1:0]    id;
	} slot_t;

	// ring control, common to every cell
	typedef struct packed {
		logic shift;
		logic dec;
	} ring_ctl_t;

endpackage

[hdl/ltp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltp_cell
// One slot of the task ring: load, sleep countdown, shift to neighbor.
// ----------------------------------------------------------------------------
module ltp_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ltp_pkg::ring_ctl_t ctl,
	input  logic              wr_en,
	input  ltp_pkg::slot_t    wr_data,
	input  ltp_pkg::slot_t    nxt,
	output ltp_pkg::slot_t    cur
);

	ltp_pkg::slot_t slot_q;
	logic [ltp_pkg::SLEEP_W-1:0] sleep_dec;

	assign sleep_dec = slot_q.sleep - 1'b1;
	assign cur = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			priority if (wr_en) begin
				slot_q <= wr_data;
			end else if (ctl.shift) begin
				slot_q <= nxt;
			end else if (ctl.dec && CELL_IDX != 0 && slot_q.sleep != '0) begin
				slot_q.sleep <= sleep_dec;
				if (sleep_dec == '0)
					slot_q.rdy <= 1'b1;
			end
		end
	end

endmodule

[hdl/ltp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltp_div #(
	parameter int NW = 27,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          fin,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          fin_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den};
	assign fin   = fin_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

[hdl/lottery_task_picker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_task_picker_top
// Lottery scheduler over a ring of task slot cells.
// ----------------------------------------------------------------------------
// A write beat (func=1) loads one slot and returns its echo on the next
// cycle. A schedule beat (func=0) keeps busy high while it counts the
// sleepers down, rotates the slot ring once to total the weights, then
// again while a bit-serial divider turns each weight, as a PW-bit product
// (19 bits at defaults), into tickets for the live slots up to and
// including the one the draw lands in (all live slots when it lands in
// none); with no live slot it ends after the first rotation. done marks
// the one-cycle result in the same cycle busy drops, which the receiver
// cannot stall.
module lottery_task_picker_top #(
	parameter int SLOTS        = ltp_pkg::SLOTS_DEF,
	parameter int PRIO_CEILING = ltp_pkg::CEILING_DEF,
	parameter int TICKETS      = ltp_pkg::TICKETS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [ltp_pkg::DRAW_W-1:0]   draw,
	input  logic [ltp_pkg::SLOT_W-1:0]   slot_index,
	input  logic [ltp_pkg::ID_W-1:0]     task_id,
	input  logic [ltp_pkg::PRIO_W-1:0]   task_priority,
	input  logic                         task_occupied,
	input  logic                         task_ready,
	input  logic [ltp_pkg::SLEEP_W-1:0]  task_sleep,
	output logic                         done,
	output logic [ltp_pkg::SLOT_W-1:0]   chosen_slot,
	output logic [ltp_pkg::ID_W-1:0]     chosen_id,
	output logic                         idle_fallback
);

	localparam int CW  = $clog2(PRIO_CEILING + 8);
	localparam int WW  = 2 * CW;
	localparam int TW  = WW + $clog2(SLOTS);
	localparam int QW  = $clog2(TICKETS + 1);
	localparam int PW  = WW + QW;
	localparam int FW  = (QW > ltp_pkg::DRAW_W) ? QW : ltp_pkg::DRAW_W;
	localparam int POSW = $clog2(SLOTS);
	localparam int SIW = (POSW > ltp_pkg::SLOT_W) ? POSW : ltp_pkg::SLOT_W;

	typedef enum logic [2:0] {ST_IDLE, ST_DEC, ST_SUM, ST_SCAN, ST_MUL, ST_DIV} state_t;

	state_t                      state_q;
	logic [POSW-1:0]             pos_q;
	logic [TW-1:0]               total_q;
	logic                        any_q;
	logic [FW-1:0]               filled_q;
	logic                        found_q;
	logic [ltp_pkg::DRAW_W-1:0]  draw_q;
	logic [POSW-1:0]             pick_q;
	logic [ltp_pkg::ID_W-1:0]    pick_id_q;
	logic [ltp_pkg::ID_W-1:0]    id0_q;
	logic [PW-1:0]               prod_q;
	logic                        done_q;
	logic [ltp_pkg::SLOT_W-1:0]  slot_q;
	logic [ltp_pkg::ID_W-1:0]    id_q;
	logic                        idle_q;

	ltp_pkg::slot_t    ring [SLOTS];
	ltp_pkg::slot_t    wr_data;
	ltp_pkg::ring_ctl_t ctl;
	logic              wr_go;
	logic              live0;
	logic              last_pos;
	logic [CW-1:0]     ceil_c;
	logic [CW-1:0]     prio_c;
	logic [CW-1:0]     mag;
	logic [WW-1:0]     weight;
	logic              div_fin;
	logic [PW-1:0]     div_quo;
	logic [FW-1:0]     filled_n;
	logic              scan_skip;

	assign wr_go   = start && !busy && func == ltp_pkg::FUNC_WRITE;
	assign wr_data = '{occ: task_occupied, rdy: task_ready, prio: task_priority,
		sleep: task_sleep, id: task_id};

	// cell 0 shows the slot numbered pos_q while the ring turns
	assign live0    = ring[0].occ && ring[0].rdy && pos_q != '0;
	assign last_pos = pos_q == POSW'(SLOTS - 1);
	assign ceil_c   = CW'(PRIO_CEILING);
	assign prio_c   = CW'(ring[0].prio);
	assign mag      = (ceil_c >= prio_c) ? ceil_c - prio_c : prio_c - ceil_c;
	assign weight   = WW'(mag * mag);
	assign filled_n = filled_q + ((total_q != '0) ? FW'(div_quo[QW-1:0]) : '0);
	assign scan_skip = !live0 || found_q;

	always_comb begin
		ctl.dec   = state_q == ST_DEC;
		ctl.shift = (state_q == ST_SUM) || (state_q == ST_SCAN && scan_skip)
			|| (state_q == ST_DIV && div_fin);
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ltp_cell #(.CELL_IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_en   (wr_go && SIW'(slot_index) == SIW'(i)),
			.wr_data (wr_data),
			.nxt     (ring[(i + 1) % SLOTS]),
			.cur     (ring[i])
		);
	end

	ltp_div #(.NW(PW), .DW(TW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (state_q == ST_MUL),
		.num    (prod_q),
		.den    (total_q),
		.fin    (div_fin),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			pos_q   <= '0;
			any_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (func == ltp_pkg::FUNC_WRITE) begin
							done_q <= 1'b1;
							slot_q <= slot_index;
							id_q   <= task_id;
							idle_q <= 1'b0;
						end else begin
							draw_q  <= draw;
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					pos_q   <= '0;
					total_q <= '0;
					any_q   <= 1'b0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (pos_q == '0)
						id0_q <= ring[0].id;
					if (live0) begin
						any_q   <= 1'b1;
						total_q <= total_q + TW'(weight);
					end
					if (last_pos) begin
						pos_q    <= '0;
						filled_q <= '0;
						found_q  <= 1'b0;
						pick_q   <= '0;
						if (!any_q && !live0) begin
							done_q  <= 1'b1;
							slot_q  <= '0;
							id_q    <= id0_q;
							idle_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (!scan_skip) begin
						prod_q  <= PW'(weight) * PW'(TICKETS);
						state_q <= ST_MUL;
					end else if (last_pos) begin
						done_q  <= 1'b1;
						slot_q  <= ltp_pkg::SLOT_W'(pick_q);
						id_q    <= pick_id_q;
						idle_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_fin) begin
						filled_q <= filled_n;
						found_q  <= FW'(draw_q) < filled_n;
						if (last_pos) begin
							done_q  <= 1'b1;
							slot_q  <= ltp_pkg::SLOT_W'(pos_q);
							id_q    <= ring[0].id;
							idle_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							pick_q    <= pos_q;
							pick_id_q <= ring[0].id;
							pos_q     <= pos_q + 1'b1;
							state_q   <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign chosen_slot   = slot_q;
	assign chosen_id     = id_q;
	assign idle_fallback = idle_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while step still running");

	a_fallback_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		done && idle_fallback |-> chosen_slot == '0)
		else $error("idle fallback with nonzero slot");

	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == ltp_pkg::FUNC_SCHED |=> busy && !done)
		else $error("schedule beat did not start a step");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives write and schedule beats into the lottery task picker, predicts
// each pick from a private copy of the slot table and checks every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NSLOT = ltp_pkg::SLOTS_DEF;
	localparam int CEIL  = ltp_pkg::CEILING_DEF;
	localparam int TIX   = ltp_pkg::TICKETS_DEF;

	typedef struct {
		bit                          func;
		logic [ltp_pkg::DRAW_W-1:0]  draw;
		logic [ltp_pkg::SLOT_W-1:0]  idx;
		logic [ltp_pkg::ID_W-1:0]    id;
		logic [ltp_pkg::PRIO_W-1:0]  prio;
		bit                          occ;
		bit                          rdy;
		logic [ltp_pkg::SLEEP_W-1:0] sleep;
	} beat_t;

	typedef struct {
		logic [ltp_pkg::SLOT_W-1:0] slot;
		logic [ltp_pkg::ID_W-1:0]   id;
		bit                         idle;
	} pick_t;

	logic clk = 0, arst_n = 0, start = 0, busy, done;
	logic func = 0, task_occupied = 0, task_ready = 0, idle_fallback;
	logic [ltp_pkg::DRAW_W-1:0] draw = '0;
	logic [ltp_pkg::SLOT_W-1:0] slot_index = '0, chosen_slot;
	logic [ltp_pkg::ID_W-1:0] task_id = '0, chosen_id;
	logic [ltp_pkg::PRIO_W-1:0] task_priority = '0;
	logic [ltp_pkg::SLEEP_W-1:0] task_sleep = '0;

	lottery_task_picker_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// private slot table
	bit                          m_occ[NSLOT], m_rdy[NSLOT];
	logic [ltp_pkg::PRIO_W-1:0]  m_prio[NSLOT];
	logic [ltp_pkg::SLEEP_W-1:0] m_sleep[NSLOT];
	logic [ltp_pkg::ID_W-1:0]    m_id[NSLOT];

	beat_t pending[$];
	pick_t picks_due[$];
	int errors = 0, n_sched = 0, n_idle = 0;
	beat_t cur;
	logic busy_at_pos = 1;
	int gap = 0;

	function automatic pick_t lottery_pick(beat_t b);
		pick_t r;
		longint total, filled, w;
		int p;
		bit any;
		total = 0; filled = 0; p = 0; any = 0;
		if (b.func == ltp_pkg::FUNC_WRITE) begin
			if (b.idx < NSLOT) begin
				m_id[b.idx] = b.id; m_prio[b.idx] = b.prio; m_occ[b.idx] = b.occ;
				m_rdy[b.idx] = b.rdy; m_sleep[b.idx] = b.sleep;
			end
			r.slot = b.idx; r.id = b.id; r.idle = 0;
			return r;
		end
		for (int s = 1; s < NSLOT; s++)
			if (m_sleep[s] != 0) begin
				m_sleep[s]--;
				if (m_sleep[s] == 0) m_rdy[s] = 1;
			end
		for (int s = 1; s < NSLOT; s++)
			if (m_occ[s] && m_rdy[s]) begin
				any = 1;
				w = longint'(CEIL - int'(m_prio[s]));
				total += w * w;
			end
		if (!any) begin
			r.slot = 0; r.id = m_id[0]; r.idle = 1;
			return r;
		end
		for (int s = 1; s < NSLOT; s++) begin
			if (!(m_occ[s] && m_rdy[s])) continue;
			w = longint'(CEIL - int'(m_prio[s]));
			if (total != 0) filled += (w * w * TIX) / total;
			p = s;
			if (longint'(b.draw) < filled) break;
		end
		r.slot = p[ltp_pkg::SLOT_W-1:0]; r.id = m_id[p]; r.idle = 0;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return 0;
		if (k < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	task automatic drive_next();
		beat_t b;
		b = pending.pop_front();
		cur = b;
		start <= 1; func <= b.func; draw <= b.draw; slot_index <= b.idx;
		task_id <= b.id; task_priority <= b.prio; task_occupied <= b.occ;
		task_ready <= b.rdy; task_sleep <= b.sleep;
	endtask

	// driver: presents a beat at the falling edge, drops start after acceptance unless the next beat follows at once
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_at_pos) begin
				if (gap == 0 && pending.size() > 0) drive_next();
				else start <= 0;
			end else if (!start) begin
				if (gap > 0) gap--;
				else if (pending.size() > 0) drive_next();
			end
		end
	end

	always @(posedge clk) begin
		busy_at_pos <= busy;
		if (arst_n && start && !busy) begin
			picks_due.push_back(lottery_pick(cur));
			gap = gap_len();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (picks_due.size() == 0) begin
				$display("result beat with nothing expected");
				errors++;
			end else begin
				pick_t e;
				e = picks_due.pop_front();
				if (chosen_slot !== e.slot)
					report("chosen_slot", int'(chosen_slot), int'(e.slot));
				if (chosen_id !== e.id)
					report("chosen_id", int'(chosen_id), int'(e.id));
				if (idle_fallback !== e.idle)
					report("idle_fallback", int'(idle_fallback), int'(e.idle));
				if (e.idle) n_idle++;
			end
		end
	end

	function automatic beat_t wr(int idx, int id, int prio, bit occ, bit rdy, int sl);
		beat_t b;
		b.func = ltp_pkg::FUNC_WRITE; b.draw = ltp_pkg::DRAW_W'($urandom);
		b.idx = ltp_pkg::SLOT_W'(idx); b.id = ltp_pkg::ID_W'(id);
		b.prio = ltp_pkg::PRIO_W'(prio); b.occ = occ; b.rdy = rdy;
		b.sleep = ltp_pkg::SLEEP_W'(sl);
		return b;
	endfunction

	function automatic beat_t sch(int d);
		beat_t b;
		b = wr($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		b.func = ltp_pkg::FUNC_SCHED; b.draw = ltp_pkg::DRAW_W'(d);
		return b;
	endfunction

	function automatic int rand_sleep();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return 0;
		if (k < 9) return $urandom_range(1, 6);
		return $urandom_range(0, 65535);
	endfunction

	// stimulus: directed beats first, then a random mix of writes and draws
	initial begin
		int k;
		for (int s = 0; s < NSLOT; s++) begin
			m_occ[s] = 0; m_rdy[s] = 0; m_prio[s] = 0; m_sleep[s] = 0; m_id[s] = 0;
		end
		// directed: empty table, idle slot id, extremes, smallest weight, sleepers
		pending.push_back(sch(0));
		pending.push_back(wr(0, 1023, 7, 1, 1, 65535));
		pending.push_back(sch(2047));
		pending.push_back(wr(1, 5, 0, 1, 1, 0));
		pending.push_back(sch(0));
		pending.push_back(sch(1599));
		pending.push_back(sch(2047));
		pending.push_back(wr(15, 1023, 7, 1, 1, 0));
		pending.push_back(wr(2, 0, 3, 1, 1, 0));
		pending.push_back(sch(1599));
		pending.push_back(sch(1598));
		pending.push_back(sch(1000));
		pending.push_back(wr(3, 77, 5, 1, 0, 2));
		pending.push_back(sch(1500));
		pending.push_back(sch(1500));
		pending.push_back(wr(1, 5, 0, 0, 1, 0));
		pending.push_back(wr(2, 0, 3, 1, 0, 0));
		pending.push_back(wr(3, 0, 3, 0, 0, 0));
		pending.push_back(wr(15, 9, 7, 1, 1, 0));
		pending.push_back(sch(5));
		pending.push_back(wr(15, 0, 0, 0, 0, 0));
		pending.push_back(sch(3));
		for (int i = 0; i < 1530; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45)
				pending.push_back(wr($urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 9) < 8, $urandom_range(0, 9) < 6, rand_sleep()));
			else if (k < 95) begin
				pending.push_back(sch($urandom_range(0, 1599)));
				n_sched++;
			end else begin
				pending.push_back(sch($urandom_range(1600, 2047)));
				n_sched++;
			end
		end
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending.size() == 0);
		wait (!start);
		wait (picks_due.size() == 0);
		repeat (2000) @(posedge clk);
		$display("covered %0d random schedule beats, %0d idle picks seen", n_sched, n_idle);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#50ms;
		$display("testbench: FAIL");
		$finish;
	end
endmodule

[sim.f]
hdl/ltp_pkg.sv
hdl/ltp_cell.sv
hdl/ltp_div.sv
hdl/lottery_task_picker_top.sv
test/testbench.sv
